@@ rtl/ikf_pkg.sv @@
// Shared types, constants and helper functions for the IMU tilt fusion block.
// No dependencies; every other file in rtl/ imports this package.
package ikf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
  localparam int SQRT_STEPS   = 24;
  localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam logic [2:0] CFG_Q_ANGLE   = 3'd0;
  localparam logic [2:0] CFG_Q_BIAS    = 3'd1;
  localparam logic [2:0] CFG_R_MEAS    = 3'd2;
  localparam logic [2:0] CFG_DT        = 3'd3;
  localparam logic [2:0] CFG_GAIN      = 3'd4;
  localparam logic [2:0] CFG_PITCH_OFF = 3'd5;
  localparam logic [2:0] CFG_ROLL_OFF  = 3'd6;

  localparam logic [29:0] RST_Q_ANGLE = 30'd1073742;
  localparam logic [29:0] RST_Q_BIAS  = 30'd3221225;
  localparam logic [29:0] RST_R_MEAS  = 30'd32212255;
  localparam logic [15:0] RST_DT      = 16'd655;
  localparam logic [15:0] RST_GAIN    = 16'd3996;

  typedef struct packed {
    logic [29:0]        q_angle;
    logic [29:0]        q_bias;
    logic [29:0]        r_meas;
    logic [15:0]        dt;
    logic [15:0]        gain;
    logic signed [31:0] pitch_off;
    logic signed [31:0] roll_off;
  } cfg_t;

  // One classified sample handed from the front end to the filter engine
  typedef struct packed {
    logic signed [31:0] pitch_meas;
    logic signed [31:0] roll_meas;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } meas_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
    logic signed [31:0] r;
    unique case (idx)
      5'd0:  r = 32'sd2949120;
      5'd1:  r = 32'sd1740967;
      5'd2:  r = 32'sd919879;
      5'd3:  r = 32'sd466945;
      5'd4:  r = 32'sd234379;
      5'd5:  r = 32'sd117304;
      5'd6:  r = 32'sd58666;
      5'd7:  r = 32'sd29335;
      5'd8:  r = 32'sd14668;
      5'd9:  r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Truncate toward zero to a multiple of 100 (reciprocal multiply, exact for 16 bits)
  function automatic logic signed [15:0] trunc100(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [29:0] scaled;
    logic [8:0]  quot;
    logic [15:0] whole;
    mag    = v[15] ? (~{v[15], v} + 17'd1) : {1'b0, v};
    scaled = 30'(mag) * 30'd5243;
    quot   = scaled[27:19];
    whole  = 16'(quot) * 16'd100;
    return v[15] ? -whole : whole;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (!v[39] && (|v[38:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[39] && !(&v[38:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ikf_front.sv @@
// Front end: accepts raw samples, truncates axes and computes accelerometer
// pitch/roll angles with a bit-serial square root and a vectoring CORDIC. Uses ikf_pkg.
module ikf_front import ikf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic               q_push,
  output meas_t              q_item,
  input  logic               q_full
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_SQUARE = 3'd1;
  localparam logic [2:0] F_SQRT   = 3'd2;
  localparam logic [2:0] F_CINIT  = 3'd3;
  localparam logic [2:0] F_CORDIC = 3'd4;
  localparam logic [2:0] F_PUSH   = 3'd5;

  logic [2:0]               state;
  logic signed [15:0]       ax, ay, az, gx, gy, gz;
  logic                     axis;
  logic                     zero_vec;
  logic [47:0]              rad, root, bitv;
  logic [SQRT_CNT_W-1:0]    scnt;
  logic [CORDIC_CNT_W-1:0]  ccnt;
  logic signed [27:0]       cx, cy;
  logic signed [31:0]       cz;
  logic signed [31:0]       pitch_meas, roll_meas;

  logic signed [15:0] num, sa, sb;
  logic signed [31:0] sq_a, sq_b;
  logic [31:0]        sq_sum;
  logic [47:0]        trial;
  logic signed [31:0] dz, z_next, ang;

  assign num    = axis ? ay : ax;
  assign sa     = axis ? ax : ay;
  assign sb     = az;
  assign sq_a   = sa * sa;
  assign sq_b   = sb * sb;
  assign sq_sum = sq_a + sq_b;
  assign trial  = root + bitv;
  assign dz     = atan_deg(5'(ccnt));
  assign z_next = cy[27] ? (cz - dz) : (cz + dz);
  assign ang    = zero_vec ? 32'sd0 : z_next;

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_item = '{pitch_meas: pitch_meas, roll_meas: roll_meas,
                    gyro_x: gx, gyro_y: gy, gyro_z: gz};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            ax    <= trunc100(accel_x);
            ay    <= trunc100(accel_y);
            az    <= trunc100(accel_z);
            gx    <= trunc100(gyro_x);
            gy    <= trunc100(gyro_y);
            gz    <= trunc100(gyro_z);
            axis  <= 1'b0;
            state <= F_SQUARE;
          end
        end
        F_SQUARE: begin
          rad      <= {sq_sum, 16'b0};
          root     <= '0;
          bitv     <= 48'd1 << 46;
          scnt     <= '0;
          zero_vec <= (sa == 16'sd0) && (sb == 16'sd0) && (num == 16'sd0);
          state    <= F_SQRT;
        end
        F_SQRT: begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          scnt <= scnt + 1'b1;
          if (scnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            state <= F_CINIT;
          end
        end
        F_CINIT: begin
          cx    <= {4'b0, root[23:0]};
          cy    <= {{4{num[15]}}, num, 8'b0};
          cz    <= '0;
          ccnt  <= '0;
          state <= F_CORDIC;
        end
        F_CORDIC: begin
          // Rotate toward y = 0
          if (cy[27]) begin
            cx <= cx - (cy >>> ccnt);
            cy <= cy + (cx >>> ccnt);
          end else begin
            cx <= cx + (cy >>> ccnt);
            cy <= cy - (cx >>> ccnt);
          end
          cz   <= z_next;
          ccnt <= ccnt + 1'b1;
          if (ccnt == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
            if (!axis) begin
              pitch_meas <= -ang;
              axis       <= 1'b1;
              state      <= F_SQUARE;
            end else begin
              roll_meas <= ang;
              state     <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ikf_fifo.sv @@
// Two-entry queue of classified samples between front end and filter engine.
// Depends on ikf_pkg for meas_t.
module ikf_fifo import ikf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  meas_t din,
  output logic  full,
  input  logic  pop,
  output meas_t dout,
  output logic  empty
);

  meas_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wr_ptr] <= din;
        wr_ptr      <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

@@ rtl/ikf_div.sv @@
// Two-lane restoring divider for Kalman gains: (num << 30) / den, toward zero,
// saturated to 32 bits. One quotient bit per cycle. Uses ikf_pkg.
module ikf_div import ikf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num0,
  input  logic signed [31:0] num1,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [31:0] q0,
  output logic signed [31:0] q1
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          den_r;
  logic [31:0]          rem [2];
  logic [31:0]          low [2];
  logic [31:0]          quo [2];
  logic                 neg [2];
  logic                 ovf [2];

  logic signed [31:0] num [2];
  logic [31:0]        mag [2];
  logic [32:0]        trial [2];
  logic               ge [2];
  logic signed [31:0] res [2];

  always_comb begin
    num[0] = num0;
    num[1] = num1;
    for (int i = 0; i < 2; i++) begin
      mag[i]   = num[i][31] ? (~num[i] + 32'd1) : num[i];
      trial[i] = {rem[i], low[i][31]};
      ge[i]    = trial[i] >= {1'b0, den_r};
      if (neg[i]) begin
        res[i] = (ovf[i] || (quo[i][31] && (|quo[i][30:0]))) ? 32'sh8000_0000 : -quo[i];
      end else begin
        res[i] = (ovf[i] || quo[i][31]) ? 32'sh7FFF_FFFF : quo[i];
      end
    end
  end

  assign q0 = res[0];
  assign q1 = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        cnt   <= DIV_CNT_W'(DIV_STEPS);
        busy  <= 1'b1;
        for (int i = 0; i < 2; i++) begin
          rem[i] <= {2'b0, mag[i][31:2]};
          low[i] <= {mag[i][1:0], 30'b0};
          ovf[i] <= {2'b0, mag[i][31:2]} >= den;
          neg[i] <= num[i][31];
          quo[i] <= '0;
        end
      end else if (busy) begin
        for (int i = 0; i < 2; i++) begin
          rem[i] <= ge[i] ? 32'(trial[i] - {1'b0, den_r}) : trial[i][31:0];
          quo[i] <= {quo[i][30:0], ge[i]};
          low[i] <= low[i] << 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ikf_back.sv @@
// Filter engine: yaw integration and the two angle/bias Kalman filters,
// sequenced over one shared multiplier and the ikf_div gain divider. Uses ikf_pkg.
module ikf_back import ikf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  meas_t              q_item,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] pitch_deg,
  output logic signed [31:0] roll_deg,
  output logic signed [31:0] yaw_deg
);

  localparam logic [4:0] B_IDLE = 5'd0;
  localparam logic [4:0] B_SEED = 5'd1;
  localparam logic [4:0] B_Y1   = 5'd2;
  localparam logic [4:0] B_Y2   = 5'd3;
  localparam logic [4:0] B_K0   = 5'd4;
  localparam logic [4:0] B_K1   = 5'd5;
  localparam logic [4:0] B_K2   = 5'd6;
  localparam logic [4:0] B_K3   = 5'd7;
  localparam logic [4:0] B_K4   = 5'd8;
  localparam logic [4:0] B_K5   = 5'd9;
  localparam logic [4:0] B_K6   = 5'd10;
  localparam logic [4:0] B_K7   = 5'd11;
  localparam logic [4:0] B_K8   = 5'd12;
  localparam logic [4:0] B_DIV  = 5'd13;
  localparam logic [4:0] B_K9   = 5'd14;
  localparam logic [4:0] B_K10  = 5'd15;
  localparam logic [4:0] B_K11  = 5'd16;
  localparam logic [4:0] B_K12  = 5'd17;
  localparam logic [4:0] B_K13  = 5'd18;
  localparam logic [4:0] B_K14  = 5'd19;
  localparam logic [4:0] B_K15  = 5'd20;
  localparam logic [4:0] B_OUT  = 5'd21;

  function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  logic [4:0]         state;
  meas_t              item;
  logic               fsel;
  logic               first;
  logic signed [31:0] angle [2];
  logic signed [31:0] bias [2];
  logic signed [31:0] pcov [2][4];
  logic [31:0]        yaw;
  logic signed [31:0] rate, dp11, inn, p00, p01, pf, rf;
  logic signed [34:0] inner;
  logic signed [32:0] ssum;
  logic signed [69:0] prod;
  logic               out_valid;

  logic signed [32:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [68:0] mul_p;
  logic signed [39:0] sh16, sh30;
  logic signed [15:0] gyro_f;
  logic signed [31:0] meas_f;
  logic signed [31:0] p0, p1, p2, p3, ang_f, bias_f;
  logic               s_pos;
  logic               div_start, div_done;
  logic signed [31:0] k0, k1;
  logic signed [32:0] dt_a, k0_a, k1_a;

  assign p0     = pcov[fsel][0];
  assign p1     = pcov[fsel][1];
  assign p2     = pcov[fsel][2];
  assign p3     = pcov[fsel][3];
  assign ang_f  = angle[fsel];
  assign bias_f = bias[fsel];
  assign gyro_f = fsel ? item.gyro_x : item.gyro_y;
  assign meas_f = fsel ? item.roll_meas : item.pitch_meas;
  assign sh16   = prod[55:16];
  assign sh30   = prod[69:30];
  assign s_pos  = !ssum[32] && (ssum != 33'sd0);
  assign dt_a   = $signed({17'b0, cfg.dt});
  assign k0_a   = $signed({k0[31], k0});
  assign k1_a   = $signed({k1[31], k1});

  // Operand select for the shared multiplier; the product lands in prod next cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      B_SEED: begin
        mul_a = $signed({{17{item.gyro_z[15]}}, item.gyro_z});
        mul_b = $signed({20'b0, cfg.gain});
      end
      B_Y1: begin
        mul_a = dt_a;
        mul_b = $signed({{4{prod[31]}}, prod[31:0]});
      end
      B_K0: begin
        mul_a = $signed({{17{gyro_f[15]}}, gyro_f});
        mul_b = $signed({20'b0, cfg.gain});
      end
      B_K2: begin
        mul_a = dt_a;
        mul_b = $signed({{4{rate[31]}}, rate});
      end
      B_K3: begin
        mul_a = dt_a;
        mul_b = $signed({{4{p3[31]}}, p3});
      end
      B_K5: begin
        mul_a = dt_a;
        mul_b = $signed({inner[34], inner});
      end
      B_K6: begin
        mul_a = $signed({3'b0, cfg.q_bias});
        mul_b = $signed({20'b0, cfg.dt});
      end
      B_K9: begin
        mul_a = k0_a;
        mul_b = $signed({{4{inn[31]}}, inn});
      end
      B_K10: begin
        mul_a = k1_a;
        mul_b = $signed({{4{inn[31]}}, inn});
      end
      B_K11: begin
        mul_a = k0_a;
        mul_b = $signed({{4{p00[31]}}, p00});
      end
      B_K12: begin
        mul_a = k0_a;
        mul_b = $signed({{4{p01[31]}}, p01});
      end
      B_K13: begin
        mul_a = k1_a;
        mul_b = $signed({{4{p00[31]}}, p00});
      end
      B_K14: begin
        mul_a = k1_a;
        mul_b = $signed({{4{p01[31]}}, p01});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign div_start = (state == B_K8) && s_pos;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign empty     = !out_valid;

  ikf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num0  (p0),
    .num1  (p2),
    .den   (ssum[31:0]),
    .done  (div_done),
    .q0    (k0),
    .q1    (k1)
  );

  always_ff @(posedge clk) begin
    prod <= {mul_p[68], mul_p};
    if (rst) begin
      state     <= B_IDLE;
      first     <= 1'b1;
      out_valid <= 1'b0;
      fsel      <= 1'b0;
      yaw       <= '0;
      for (int f = 0; f < 2; f++) begin
        angle[f] <= '0;
        bias[f]  <= '0;
        for (int k = 0; k < 4; k++) begin
          pcov[f][k] <= '0;
        end
      end
    end else begin
      // Fill the result slot from B_OUT, or drop the result once it is popped
      if ((state == B_OUT) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            item  <= q_item;
            state <= B_SEED;
          end
        end
        B_SEED: begin
          // Seed both filters from the accelerometer on the first sample
          if (first) begin
            angle[0] <= item.pitch_meas;
            angle[1] <= item.roll_meas;
            first    <= 1'b0;
          end
          state <= B_Y1;
        end
        B_Y1: state <= B_Y2;
        B_Y2: begin
          yaw <= yaw + prod[47:16];
          if (cfg.dt == 16'd0) begin
            pf    <= '0;
            rf    <= '0;
            state <= B_OUT;
          end else begin
            fsel  <= 1'b0;
            state <= B_K0;
          end
        end
        B_K0: state <= B_K1;
        B_K1: begin
          rate  <= sat32(ext40(prod[31:0]) - ext40(bias_f));
          state <= B_K2;
        end
        B_K2: state <= B_K3;
        B_K3: begin
          angle[fsel] <= sat32(ext40(ang_f) + sh16);
          state       <= B_K4;
        end
        B_K4: begin
          dp11  <= prod[47:16];
          inner <= $signed({{3{prod[47]}}, prod[47:16]}) - $signed({{3{p1[31]}}, p1})
                   - $signed({{3{p2[31]}}, p2}) + $signed({5'b0, cfg.q_angle});
          state <= B_K5;
        end
        B_K5: begin
          pcov[fsel][1] <= sat32(ext40(p1) - ext40(dp11));
          pcov[fsel][2] <= sat32(ext40(p2) - ext40(dp11));
          state         <= B_K6;
        end
        B_K6: begin
          pcov[fsel][0] <= sat32(ext40(p0) + sh16);
          state         <= B_K7;
        end
        B_K7: begin
          pcov[fsel][3] <= sat32(ext40(p3) + sh16);
          ssum          <= $signed({p0[31], p0}) + $signed({3'b0, cfg.r_meas});
          state         <= B_K8;
        end
        B_K8: begin
          if (s_pos) begin
            inn   <= sat32(ext40(meas_f) - ext40(ang_f));
            p00   <= p0;
            p01   <= p1;
            state <= B_DIV;
          end else begin
            // Skip the correction: the prediction is the filter output
            if (!fsel) begin
              pf    <= ang_f;
              fsel  <= 1'b1;
              state <= B_K0;
            end else begin
              rf    <= ang_f;
              state <= B_OUT;
            end
          end
        end
        B_DIV: begin
          if (div_done) begin
            state <= B_K9;
          end
        end
        B_K9: state <= B_K10;
        B_K10: begin
          angle[fsel] <= sat32(ext40(ang_f) + sh30);
          state       <= B_K11;
        end
        B_K11: begin
          bias[fsel] <= sat32(ext40(bias_f) + sh30);
          state      <= B_K12;
        end
        B_K12: begin
          pcov[fsel][0] <= sat32(ext40(p0) - sh30);
          state         <= B_K13;
        end
        B_K13: begin
          pcov[fsel][1] <= sat32(ext40(p1) - sh30);
          state         <= B_K14;
        end
        B_K14: begin
          pcov[fsel][2] <= sat32(ext40(p2) - sh30);
          state         <= B_K15;
        end
        B_K15: begin
          pcov[fsel][3] <= sat32(ext40(p3) - sh30);
          if (!fsel) begin
            pf    <= ang_f;
            fsel  <= 1'b1;
            state <= B_K0;
          end else begin
            rf    <= ang_f;
            state <= B_OUT;
          end
        end
        B_OUT: begin
          // Hold until the result slot is free or drains this cycle
          if (!out_valid || pop) begin
            pitch_deg <= sat32(ext40(pf) - ext40(cfg.pitch_off));
            roll_deg  <= sat32(ext40(rf) - ext40(cfg.roll_off));
            yaw_deg   <= yaw;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_gain_ready: assert property (@(posedge clk) disable iff (rst)
    (state == B_K9) |-> $past(div_done))
    else $error("gain update entered without divider completion");

  a_seed_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_Y1) |-> !first)
    else $error("first-sample seed still pending after seeding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT) && out_valid && !pop |=> (state == B_OUT))
    else $error("result overwritten while slot occupied");

  a_take_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_SEED))
    else $error("queue pop did not start a sample");

endmodule

@@ rtl/imu_kalman_tilt_fusion.sv @@
// IMU tilt fusion: pitch/roll angle-and-bias Kalman filters plus integrated yaw.
// Throughput is set by the filter engine: its gain divider runs once per filter and
//   all its arithmetic shares a single multiplier; with dt = 0 both filters are skipped.
//   The front end can take a new request while the engine still works on earlier ones.
// Reset: synchronous rst clears filter state, yaw and queues, loads default registers
//   and arms the first-sample seed.
module imu_kalman_tilt_fusion import ikf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // sample input queue side
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  // result queue side
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] pitch_deg,
  output logic signed [31:0] roll_deg,
  output logic signed [31:0] yaw_deg,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  logic  fq_push, fq_full, fq_pop, fq_empty;
  meas_t fq_din, fq_dout;

  // Registers take a write every cycle; write them only while no request is in flight
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.q_angle   <= RST_Q_ANGLE;
      cfg.q_bias    <= RST_Q_BIAS;
      cfg.r_meas    <= RST_R_MEAS;
      cfg.dt        <= RST_DT;
      cfg.gain      <= RST_GAIN;
      cfg.pitch_off <= '0;
      cfg.roll_off  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_Q_ANGLE:   cfg.q_angle   <= cfg_data[29:0];
        CFG_Q_BIAS:    cfg.q_bias    <= cfg_data[29:0];
        CFG_R_MEAS:    cfg.r_meas    <= cfg_data[29:0];
        CFG_DT:        cfg.dt        <= cfg_data[15:0];
        CFG_GAIN:      cfg.gain      <= cfg_data[15:0];
        CFG_PITCH_OFF: cfg.pitch_off <= cfg_data;
        CFG_ROLL_OFF:  cfg.roll_off  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: truncation, accelerometer angles by square root and CORDIC
  ikf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .gyro_x  (gyro_x),
    .gyro_y  (gyro_y),
    .gyro_z  (gyro_z),
    .q_push  (fq_push),
    .q_item  (fq_din),
    .q_full  (fq_full)
  );

  // Decouple angle extraction from filtering
  ikf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_din),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_dout),
    .empty (fq_empty)
  );

  // Filter engine with its own result slot
  ikf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (fq_empty),
    .q_pop     (fq_pop),
    .q_item    (fq_dout),
    .pop       (pop),
    .empty     (empty),
    .pitch_deg (pitch_deg),
    .roll_deg  (roll_deg),
    .yaw_deg   (yaw_deg)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for imu_kalman_tilt_fusion: drives IMU samples through the
// push/full queue, predicts each pitch/roll/yaw result and checks it at pop/empty.
// Depends on rtl/ikf_pkg.sv (register indexes, CORDIC_STEPS) and the DUT RTL.
`timescale 1ns / 1ps

module tb;
  import ikf_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct {
    logic signed [31:0] pitch, roll, yaw;
  } attitude_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic               pop = 1'b0;
  logic               empty;
  logic signed [31:0] pitch_deg, roll_deg, yaw_deg;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  imu_kalman_tilt_fusion DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted attitude, oldest first, and the error count.
  attitude_t attitude_q[$];
  int        fail_count = 0;

  // Shadow copy of the registers and the filter state.
  longint q_angle, q_bias, r_meas, dt_reg, gain_reg, pitch_off, roll_off;
  int     f_angle[2], f_bias[2], f_cov[8];
  bit [31:0] yaw_acc;
  bit        seed_pending;

  // atan(2^-i) in Q16.16 degrees
  int atan_lut[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                       14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
                       2, 1, 0};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(a * b / 2^sh), split so the partial products stay inside 64 bits
  function automatic longint mul_floor(longint a, longint b, int sh);
    longint hi, lo;
    hi = b >>> 16;
    lo = b - hi * 65536;
    return (a * hi + ((a * lo) >>> 16)) >>> (sh - 16);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // atan2(num, |(a, b)|) in Q16.16 degrees by vectoring CORDIC
  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint x, y, z, nx, ny;
    int     steps;
    x = int_sqrt(longint'(a * a + b * b) << 16);
    y = num * 256;
    z = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < steps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  // One predict/correct pass of the angle-bias filter f (0 pitch, 1 roll).
  function automatic longint track_axis(int f, longint meas, longint rate_in, longint dt);
    longint ang, bs, rate, dp11, inner, s, k0, k1, inn, p00, p01;
    int     b;
    b = f * 4;
    ang = f_angle[f];
    bs = f_bias[f];
    rate = clamp32(rate_in - bs);
    ang = clamp32(ang + mul_floor(dt, rate, 16));
    dp11 = mul_floor(dt, f_cov[b+3], 16);
    inner = dp11 - f_cov[b+1] - f_cov[b+2] + q_angle;
    f_cov[b]   = int'(clamp32(f_cov[b] + mul_floor(dt, inner, 16)));
    f_cov[b+1] = int'(clamp32(f_cov[b+1] - dp11));
    f_cov[b+2] = int'(clamp32(f_cov[b+2] - dp11));
    f_cov[b+3] = int'(clamp32(f_cov[b+3] + mul_floor(q_bias, dt, 16)));
    f_angle[f] = int'(ang);
    s = longint'(f_cov[b]) + r_meas;
    // skip the correction when the innovation variance is not positive
    if (s <= 0) return ang;
    k0 = clamp32((longint'(f_cov[b]) * 1073741824) / s);
    k1 = clamp32((longint'(f_cov[b+2]) * 1073741824) / s);
    inn = clamp32(meas - ang);
    ang = clamp32(ang + mul_floor(k0, inn, 30));
    bs = clamp32(bs + mul_floor(k1, inn, 30));
    p00 = f_cov[b];
    p01 = f_cov[b+1];
    f_cov[b]   = int'(clamp32(f_cov[b] - mul_floor(k0, p00, 30)));
    f_cov[b+1] = int'(clamp32(f_cov[b+1] - mul_floor(k0, p01, 30)));
    f_cov[b+2] = int'(clamp32(f_cov[b+2] - mul_floor(k1, p00, 30)));
    f_cov[b+3] = int'(clamp32(f_cov[b+3] - mul_floor(k1, p01, 30)));
    f_angle[f] = int'(ang);
    f_bias[f] = int'(bs);
    return ang;
  endfunction

  function automatic attitude_t fuse_sample(imu_sample_t s);
    longint    v[6];
    longint    pm, rm, pf, rf;
    attitude_t r;
    v[0] = s.ax; v[1] = s.ay; v[2] = s.az; v[3] = s.gx; v[4] = s.gy; v[5] = s.gz;
    // truncate toward zero to a multiple of 100
    foreach (v[i]) v[i] = (v[i] / 100) * 100;
    pm = -tilt_angle(v[0], v[1], v[2]);
    rm = tilt_angle(v[1], v[0], v[2]);
    if (seed_pending) begin
      f_angle[0] = int'(pm);
      f_angle[1] = int'(rm);
      seed_pending = 1'b0;
    end
    yaw_acc += 32'(mul_floor(dt_reg, v[5] * gain_reg, 16));
    pf = 0;
    rf = 0;
    // a zero sample period freezes both filters
    if (dt_reg > 0) begin
      pf = track_axis(0, pm, v[4] * gain_reg, dt_reg);
      rf = track_axis(1, rm, v[3] * gain_reg, dt_reg);
    end
    r.pitch = 32'(clamp32(pf - pitch_off));
    r.roll = 32'(clamp32(rf - roll_off));
    r.yaw = yaw_acc;
    return r;
  endfunction

  // Random gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one sample request; push stays high when no gap follows.
  task automatic send_sample(imu_sample_t s);
    int gap;
    @(negedge clk);
    push <= 1'b1;
    accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
    gyro_x <= s.gx; gyro_y <= s.gy; gyro_z <= s.gz;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    attitude_q.push_back(fuse_sample(s));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (attitude_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_Q_ANGLE:   q_angle = data[29:0];
      CFG_Q_BIAS:    q_bias = data[29:0];
      CFG_R_MEAS:    r_meas = data[29:0];
      CFG_DT:        dt_reg = data[15:0];
      CFG_GAIN:      gain_reg = data[15:0];
      CFG_PITCH_OFF: pitch_off = signed'(data);
      CFG_ROLL_OFF:  roll_off = signed'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm,
                           logic [31:0] dt, logic [31:0] gn, logic [31:0] po,
                           logic [31:0] ro);
    write_reg(CFG_Q_ANGLE, qa);
    write_reg(CFG_Q_BIAS, qb);
    write_reg(CFG_R_MEAS, rm);
    write_reg(CFG_DT, dt);
    write_reg(CFG_GAIN, gn);
    write_reg(CFG_PITCH_OFF, po);
    write_reg(CFG_ROLL_OFF, ro);
  endtask

  function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy, int gz);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    return s;
  endfunction

  // Mostly a plausible sensor at rest or tilting: gravity plus noise, modest rates.
  // The rest is full-range noise so every input bit toggles.
  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    int g;
    if ($urandom_range(0, 3) == 0) begin
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      g = $urandom_range(8000, 16384);
      s = mk($urandom_range(0, 2*g) - g, $urandom_range(0, 2*g) - g, g,
             $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
             $urandom_range(0, 4000) - 2000);
      if ($urandom_range(0, 1)) s.az = -s.az;
    end
    return s;
  endfunction

  // Result side: random pop stalls plus a long hold-off on request.
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      stall_left = pick_gap();
      pop <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    attitude_t e;
    if (!rst && pop && !empty) begin
      if (attitude_q.size() == 0) begin
        $error("result popped with nothing expected");
        fail_count++;
      end else begin
        e = attitude_q.pop_front();
        if (pitch_deg !== e.pitch) begin
          $error("pitch_deg expected %0d actual %0d", e.pitch, pitch_deg);
          fail_count++;
        end
        if (roll_deg !== e.roll) begin
          $error("roll_deg expected %0d actual %0d", e.roll, roll_deg);
          fail_count++;
        end
        if (yaw_deg !== e.yaw) begin
          $error("yaw_deg expected %0d actual %0d", e.yaw, yaw_deg);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, the first-sample seed, zero accel, zero dt, zero gain and zero noise.
  task automatic test_directed();
    send_sample(mk(0, 0, 0, 0, 0, 0));
    send_sample(mk(0, 0, 16384, 0, 0, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(mk(99, -99, 199, -150, 150, 1));
    send_sample(mk(16384, 0, 0, 0, 0, 0));
    send_sample(mk(0, -16384, 0, 0, 0, 0));
    send_sample(mk(-32768, 32767, 0, 1000, -1000, 500));
    send_sample(mk(0, 0, -16384, -32768, 32767, -32768));
    stop_push();
    wait_drained();
    // zero sample period: filters hold, yaw holds
    write_reg(CFG_DT, 0);
    write_reg(CFG_PITCH_OFF, 32'h8000_0000);
    write_reg(CFG_ROLL_OFF, 32'h7FFF_FFFF);
    send_sample(mk(1000, 2000, 3000, 4000, 5000, 6000));
    send_sample(mk(-32768, 32767, 100, 32767, -32768, 32767));
    stop_push();
    wait_drained();
    // zero gyro gain
    write_all(RST_Q_ANGLE, RST_Q_BIAS, RST_R_MEAS, RST_DT, 0, 0, 0);
    send_sample(mk(4000, -3000, 15000, 32767, -32768, 32767));
    send_sample(mk(-4000, 3000, 15000, -32768, 32767, -32768));
    stop_push();
    wait_drained();
    // zero noise: drives P00 + R to zero or below so the correction is skipped
    write_all(0, 0, 0, 65535, 65535, 0, 0);
    repeat (8) send_sample(rand_sample());
    stop_push();
    wait_drained();
  endtask

  // Several register settings, extremes among them, each with a random burst.
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(RST_Q_ANGLE, RST_Q_BIAS, RST_R_MEAS, RST_DT, RST_GAIN, 0, 0);
        1: write_all(30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 65535, 65535,
                     32'h7FFF_FFFF, 32'h8000_0000);
        2: write_all(0, 0, 30'h3FFF_FFFF, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        default: write_all($urandom_range(0, 50000000), $urandom_range(0, 50000000),
                           $urandom_range(0, 30'h3FFF_FFFF), $urandom_range(1, 65535),
                           $urandom_range(1, 65535), $urandom, $urandom);
      endcase
      repeat (110) send_sample(rand_sample());
      stop_push();
      wait_drained();
    end
  endtask

  // Hold off the result side long enough that the block fills and stalls push.
  task automatic test_backpressure();
    write_all(RST_Q_ANGLE, RST_Q_BIAS, RST_R_MEAS, RST_DT, RST_GAIN,
              $urandom_range(0, 655360), $urandom_range(0, 655360));
    hold_req = 3000;
    repeat (40) send_sample(rand_sample());
    stop_push();
    wait_drained();
  endtask

  // Let the pipeline run dry between short bursts.
  task automatic test_drain_bursts();
    for (int k = 0; k < 6; k++) begin
      repeat ($urandom_range(1, 8)) send_sample(rand_sample());
      stop_push();
      wait_drained();
    end
  endtask

  initial begin
    q_angle = RST_Q_ANGLE; q_bias = RST_Q_BIAS; r_meas = RST_R_MEAS;
    dt_reg = RST_DT; gain_reg = RST_GAIN; pitch_off = 0; roll_off = 0;
    foreach (f_angle[i]) begin
      f_angle[i] = 0;
      f_bias[i] = 0;
    end
    foreach (f_cov[i]) f_cov[i] = 0;
    yaw_acc = '0;
    seed_pending = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phases();
    test_backpressure();
    test_drain_bursts();

    wait_drained();
    repeat (250) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: roughly ten times the slowest expected run.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
